FILE: hdl/int32_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_assert.svh
// Assertion macros for the decimal text converter. They expect clk and rst
// to be in scope where they are used.
// ----------------------------------------------------------------------------
`ifndef INT32_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT32_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2DA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2DA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/i2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants of the decimal text converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int BITCNT_W   = $clog2(WORD_W);
  localparam int REMAIN_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Per-cycle command broadcast to every cell of the digit chain.
  typedef struct packed {
    logic clear;      // zero the digit
    logic bit_shift;  // add-3 correction, then shift one binary bit in
    logic dig_shift;  // take the whole digit of the lower neighbor
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/i2da_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_cell
// One BCD digit of the conversion chain: clear, double-dabble step or digit shift.
// ----------------------------------------------------------------------------
module i2da_cell (
  input  logic               clk,
  input  i2da_pkg::cell_ctl_t ctl,
  input  logic               bit_in,   // from lower neighbor (or binary word)
  input  i2da_pkg::digit_t   dig_in,   // digit of lower neighbor
  output logic               bit_out,  // carry to upper neighbor
  output i2da_pkg::digit_t   digit
);
  import i2da_pkg::*;

  digit_t adj;

  // >= 5 gets +3 so the following doubling carries into the next decade
  assign adj     = (digit >= DIGIT_FIVE) ? digit + DIGIT_THREE : digit;
  assign bit_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.bit_shift) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctl.dig_shift) begin
      digit <= dig_in;
    end
  end

endmodule

FILE: hdl/int32_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// 32-bit word to decimal ASCII text, most significant character first.
// ----------------------------------------------------------------------------
// One item in (s_tuser = 1: signed, 0: unsigned; s_tdata = the word) yields
// 1 to 11 character items out, '-' first for a negative signed value, no
// leading zeros, m_tlast on the final character. The block works on one item
// at a time: after acceptance the word is shifted bit by bit through a chain
// of ten BCD digit cells (double dabble), then leading zero digits are dropped
// one per cycle by shifting the chain upward, then characters leave one per
// cycle from the top cell while m_tready does not hold the output. s_tready is
// high only while the block is idle and out of reset. Reset: rst, synchronous,
// active high. No configuration registers.
// ----------------------------------------------------------------------------
`include "int32_to_decimal_ascii_assert.svh"

module int32_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] opcode: 1 = signed, 0 = unsigned
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] text_char
  output logic        m_tlast    // last character of the number
);
  import i2da_pkg::*;

  state_t state, state_next;

  logic [WORD_W-1:0]   mag;          // magnitude still being shifted out
  logic [BITCNT_W-1:0] bit_cnt;      // bits left in conversion, minus one
  logic [REMAIN_W-1:0] remaining;    // digits left in the chain
  logic                sign_pending; // '-' not yet sent

  cell_ctl_t ctl;
  logic      accept;
  logic      out_free;
  logic      load_out;
  logic      top_zero;
  logic      is_neg;

  // chain wiring: index 0 is the least significant digit
  logic   [NUM_DIGITS:0]  bit_chain;
  digit_t                 dig_chain [NUM_DIGITS+1];

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_neg   = s_tuser && s_tdata[WORD_W-1];
  assign top_zero = (dig_chain[NUM_DIGITS] == '0);

  assign bit_chain[0] = mag[WORD_W-1];
  assign dig_chain[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
      i2da_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .bit_in  (bit_chain[gi]),
        .dig_in  (dig_chain[gi]),
        .bit_out (bit_chain[gi+1]),
        .digit   (dig_chain[gi+1])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (bit_cnt == '0) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        // zero word keeps its last digit
        if (!top_zero || remaining == REMAIN_W'(1)) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && !sign_pending && remaining == REMAIN_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready      = 1'b0;
    ctl.clear     = 1'b0;
    ctl.bit_shift = 1'b0;
    ctl.dig_shift = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready  = !rst;
        ctl.clear = s_tvalid;
      end
      ST_CONVERT: begin
        ctl.bit_shift = 1'b1;
      end
      ST_SKIP: begin
        ctl.dig_shift = top_zero && remaining != REMAIN_W'(1);
      end
      ST_EMIT: begin
        load_out      = out_free;
        ctl.dig_shift = out_free && !sign_pending;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      sign_pending <= 1'b0;
      bit_cnt      <= '0;
      remaining    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        sign_pending <= is_neg;
        bit_cnt      <= BITCNT_W'(WORD_W - 1);
        remaining    <= REMAIN_W'(NUM_DIGITS);
      end
      if (ctl.bit_shift) bit_cnt <= bit_cnt - BITCNT_W'(1);
      if (ctl.dig_shift) remaining <= remaining - REMAIN_W'(1);
      if (load_out) begin
        m_tvalid <= 1'b1;
        if (sign_pending) sign_pending <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      // two's complement magnitude; -2^31 maps onto 2^31 unchanged
      mag <= is_neg ? (~s_tdata + WORD_W'(1)) : s_tdata;
    end else if (ctl.bit_shift) begin
      mag <= {mag[WORD_W-2:0], 1'b0};
    end
    if (load_out) begin
      if (sign_pending) begin
        m_tdata <= ASCII_MINUS;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig_chain[NUM_DIGITS]};
        m_tlast <= (remaining == REMAIN_W'(1));
      end
    end
  end

  // ten decades always hold a 32-bit magnitude
  `I2DA_ASSERT_IMP(a_no_overflow, state == ST_CONVERT, !bit_chain[NUM_DIGITS],
    "digit chain overflow")
  // a digit emitted never is a leading zero unless it is the only one
  `I2DA_ASSERT_IMP(a_no_lead_zero,
    state == ST_EMIT && remaining == REMAIN_W'(NUM_DIGITS) && !sign_pending,
    !top_zero || remaining == REMAIN_W'(1), "leading zero emitted")
  // the sign is never the final character
  `I2DA_ASSERT_IMP(a_sign_not_last, m_tvalid && m_tdata == ASCII_MINUS, !m_tlast,
    "sign flagged last")
  // emitting always has digits left
  `I2DA_ASSERT_IMP(a_emit_has_digit, state == ST_EMIT, remaining != '0,
    "no digit left while emitting")
  // new item only once the last character of the previous one is loaded
  `I2DA_ASSERT_NXT(a_done_last, state == ST_EMIT && state_next == ST_IDLE,
    m_tvalid && m_tlast, "item finished without last")

endmodule
